// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Holds the queue size, the entry and command types and the status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY  = 64;
    localparam int TAG_BITS  = 16;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int SCORE_W   = 32;
    localparam int PTAG_W    = 16;
    localparam int OCC_W     = 7;
    localparam int STATUS_W  = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    // one stored entry
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [TAG_BITS-1:0]       tag;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic   insert;
        logic   remove;
        t_entry entry;
    } t_cmd;

endpackage

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Compares the broadcast score with its own entry and either keeps its entry,
// takes the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  t_cmd   i_cmd,
    input  logic   i_occupied,
    input  logic   i_left_take,
    input  t_entry i_left,
    input  t_entry i_right,
    output logic   o_take,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // new entry belongs here or further up the chain
    assign o_take  = !i_occupied || (i_cmd.entry.score > r_entry.score);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.insert) begin
            if (i_left_take) begin
                n_entry = i_left;
            end else if (o_take) begin
                n_entry = i_cmd.entry;
            end
        end else if (i_cmd.remove) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: max-priority queue kept as a sorted chain of cells
// Inserts a scored, tagged entry or removes the highest-score entry.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry func, score and payload_tag;
//   func selects insert or remove of the head entry
//   output channel: o_out_valid / i_out_stall carry one result beat per input
//   beat: status, score and tag of the moved entry, occupancy after the beat
//   result: registered, the result beat follows in the cycle after the accepted input beat
//   throughput: one beat per cycle while the receiver does not stall; every
//   cell compares the broadcast score in parallel and shifts to its neighbor
//   in the same cycle, so the chain length does not slow the queue
//   equal scores leave in arrival order; an insert into a full queue returns
//   overflow, a remove from an empty queue returns underflow, neither changes
//   the stored entries
//   reset: synchronous, active low, empties the queue and drops any pending
//   result; no clearing pass is needed since slots above the count are unused
//   receiver stall: the result register holds its beat and the input side
//   stalls until the result is taken
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_func,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [PTAG_W-1:0]         i_payload_tag,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic signed [SCORE_W-1:0] o_out_score,
    output logic [PTAG_W-1:0]         o_out_tag,
    output logic [OCC_W-1:0]          o_occupancy
);

    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                r_out_valid;
    logic                n_out_valid;
    t_status             r_status;
    t_status             n_status;
    t_entry              r_result;
    t_entry              n_result;

    logic                accept;
    logic                full;
    logic                empty;
    t_cmd                cmd;
    t_entry              new_entry;

    logic   [CAPACITY-1:0] take;
    t_entry [CAPACITY-1:0] cells;

    // input side moves whenever the result slot is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign full  = (r_count == CNT_BITS'(CAPACITY));
    assign empty = (r_count == '0);

    assign new_entry.score = i_score;
    assign new_entry.tag   = TAG_BITS'(i_payload_tag);

    // broadcast command; refused beats leave the chain untouched
    assign cmd.insert = accept && (i_func == FUNC_INSERT) && !full;
    assign cmd.remove = accept && (i_func == FUNC_REMOVE) && !empty;
    assign cmd.entry  = new_entry;

    // the chain: cell 0 is the head, highest score first
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   left_take;
        t_entry left_entry;
        t_entry right_entry;

        if (g == 0) begin : g_head
            assign left_take  = 1'b0;
            assign left_entry = '0;
        end else begin : g_body
            assign left_take  = take[g-1];
            assign left_entry = cells[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = cells[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_occupied  (r_count > CNT_BITS'(g)),
            .i_left_take (left_take),
            .i_left      (left_entry),
            .i_right     (right_entry),
            .o_take      (take[g]),
            .o_entry     (cells[g])
        );
    end

    // result and count for the accepted beat
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_result    = r_result;
        if (accept) begin
            n_out_valid = 1'b1;
            n_result    = '0;
            if (i_func == FUNC_INSERT) begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_status = ST_INSERTED;
                    n_result = new_entry;
                    n_count  = r_count + 1'b1;
                end
            end else begin
                if (empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_status = ST_REMOVED;
                    n_result = cells[0];
                    n_count  = r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_result <= n_result;
    end

    // occupancy is reported with the result, so it is sampled with it
    logic [CNT_BITS-1:0] r_occ;
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_occ <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_score = r_result.score;
    assign o_out_tag   = PTAG_W'(r_result.tag);
    assign o_occupancy = OCC_W'(r_occ);

    // count never runs past the chain length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("entry count beyond capacity");

    // an accepted insert into a non-full queue grows the count by one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.insert |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance count");

    // overflow is reported only when the queue is full
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OVERFLOW)) |-> (r_occ == CNT_BITS'(CAPACITY)))
        else $error("overflow reported on a queue that is not full");

    // underflow is reported only on an empty queue
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_UNDERFLOW)) |-> (r_occ == '0))
        else $error("underflow reported on a queue that is not empty");

    // insert and remove never reach the chain together
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.insert && cmd.remove))
        else $error("insert and remove in the same cycle");

endmodule
